### src/mpm_pkg.sv
// Shared types and constants for the multi-pattern match marker.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package mpm_pkg;

  // Sizing of the pattern bank and of the history window.
  localparam int NUM_PATTERNS    = 4;
  localparam int MAX_PATTERN_LEN = 8;
  localparam int HIST_DEPTH      = MAX_PATTERN_LEN - 1;

  // Fixed register layout: four 64-bit patterns and one word of 4-bit lengths.
  localparam int PATTERN_SLOTS = 4;
  localparam int PATTERN_W     = 64;
  localparam int LEN_W         = 4;
  localparam int LENGTHS_W     = PATTERN_SLOTS * LEN_W;
  localparam int CFG_DATA_W    = PATTERN_W;
  localparam int CFG_INDEX_W   = 3;
  localparam int COUNT_W       = 3;
  localparam int POS_W         = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_A   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_B   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_C   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_D   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PAT_LENGTHS = 3'd4;

  // Characters that break a match and produce no result.
  localparam logic [7:0] BREAK_NL  = 8'h0A;
  localparam logic [7:0] BREAK_NUL = 8'h00;

  typedef logic [7:0]                               byte_t;
  typedef logic [HIST_DEPTH-1:0][7:0]               hist_t;
  typedef logic [MAX_PATTERN_LEN-1:0][7:0]          window_t;
  typedef logic [PATTERN_SLOTS-1:0][PATTERN_W-1:0]  pattern_set_t;

  // Update request from the input stage to the history register.
  typedef struct packed {
    logic  shift;
    byte_t data;
  } hist_upd_t;

endpackage

### src/mpm_history.sv
// History shift register holding the most recent characters, newest first.
// Depends on mpm_pkg for the history type and the update request struct.
`timescale 1ns / 1ps

module mpm_history
  import mpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  hist_upd_t upd,
  output hist_t     hist
);

  hist_t hist_r;
  hist_t hist_nxt;

  always_comb begin
    hist_nxt = hist_r;
    if (upd.shift) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        hist_nxt[i] = hist_r[i-1];
      end
      hist_nxt[0] = upd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else begin
      hist_r <= hist_nxt;
    end
  end

  assign hist = hist_r;

endmodule

### src/mpm_matcher.sv
// Parallel comparison of every pattern against the character window.
// Purely combinational; depends on mpm_pkg for types and sizes.
`timescale 1ns / 1ps

module mpm_matcher
  import mpm_pkg::*;
(
  input  window_t              window,
  input  pattern_set_t         patterns,
  input  logic [LENGTHS_W-1:0] lengths,
  output logic [COUNT_W-1:0]   match_count
);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN_LEN);

  logic [NUM_PATTERNS-1:0] hit;

  always_comb begin
    logic [LEN_W-1:0] len;
    logic [POS_W-1:0] pos;
    byte_t            want;
    hit = '0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      len = lengths[LEN_W*p +: LEN_W];
      if (len > LEN_MAX) begin
        len = LEN_MAX;
      end
      hit[p] = (len != '0);
      for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
        pos  = POS_W'(len - LEN_W'(k) - LEN_W'(1));
        want = patterns[p][8*pos +: 8];
        // A position inside the pattern needs an ordinary character that agrees.
        if (LEN_W'(k) < len) begin
          if (window[k] == BREAK_NUL || window[k] != want) begin
            hit[p] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    match_count = '0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      match_count = match_count + COUNT_W'(hit[p]);
    end
  end

endmodule

### src/multi_pattern_match_marker_unit.sv
// Top level of the multi-pattern match marker: configuration registers,
// input and result registers. Depends on mpm_pkg, mpm_history, mpm_matcher.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+-------------------
//   input   | in_valid, in_stall, in_byte             | one char per request
//   result  | out_valid, out_stall, out_byte,         | one result per
//           | out_match_count                         | ordinary character
//   config  | cfg_write_en, cfg_index, cfg_data       | register writes
//
// Every character passes through the input register; the match logic sits
// between that register and the result register, so a result is offered once
// its character moves on from the input register into the result register, and
// a new character is taken every cycle while in_stall is low. Newline and zero
// characters leave the input register without a result. Reset (synchronous,
// rst_n low) clears the patterns, lengths, history and both valid flags. in_stall
// rises only while the input register holds a character that cannot move because
// the result register is full and stalled.
`timescale 1ns / 1ps

module multi_pattern_match_marker_unit
  import mpm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration port.
  input  logic                   cfg_write_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input channel.
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_byte,
  // Result channel.
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic [COUNT_W-1:0]     out_match_count
);

  // Configuration registers.
  pattern_set_t         patterns_r;
  pattern_set_t         patterns_nxt;
  logic [LENGTHS_W-1:0] lengths_r;
  logic [LENGTHS_W-1:0] lengths_nxt;

  // Input register.
  logic  s1_valid_r;
  logic  s1_valid_nxt;
  byte_t s1_byte_r;
  byte_t s1_byte_nxt;

  // Result register.
  logic               out_valid_r;
  logic               out_valid_nxt;
  byte_t              out_byte_r;
  byte_t              out_byte_nxt;
  logic [COUNT_W-1:0] out_count_r;
  logic [COUNT_W-1:0] out_count_nxt;

  logic               in_take;
  logic               s1_break;
  logic               s1_advance;
  logic               out_load;
  hist_t              hist;
  hist_upd_t          hist_upd;
  window_t            window;
  logic [COUNT_W-1:0] count;

  // The user must make register writes only while the block is idle, so the match
  // logic never sees a pattern change mid-character; the block does not enforce it.
  always_comb begin
    patterns_nxt = patterns_r;
    lengths_nxt  = lengths_r;
    if (cfg_write_en) begin
      unique case (cfg_index)
        REG_PATTERN_A:   patterns_nxt[0] = cfg_data;
        REG_PATTERN_B:   patterns_nxt[1] = cfg_data;
        REG_PATTERN_C:   patterns_nxt[2] = cfg_data;
        REG_PATTERN_D:   patterns_nxt[3] = cfg_data;
        REG_PAT_LENGTHS: lengths_nxt     = cfg_data[LENGTHS_W-1:0];
        default: begin
          patterns_nxt = patterns_r;
          lengths_nxt  = lengths_r;
        end
      endcase
    end
  end

  // The input register drains whenever its character is a break, or when the
  // result register is empty or handing its result over in this cycle.
  assign s1_break   = (s1_byte_r == BREAK_NL) || (s1_byte_r == BREAK_NUL);
  assign s1_advance = s1_valid_r && (s1_break || !out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_take    = in_valid && !in_stall;
  assign out_load   = s1_advance && !s1_break;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_byte_nxt  = s1_byte_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
      s1_byte_nxt  = in_byte;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // A break enters the history as zero, which no pattern position can match.
  assign hist_upd.shift = s1_advance;
  assign hist_upd.data  = s1_break ? BREAK_NUL : s1_byte_r;

  mpm_history u_history (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (hist_upd),
    .hist  (hist)
  );

  // Window: the current character first, then the history, newest first.
  always_comb begin
    window[0] = s1_byte_r;
    for (int k = 1; k < MAX_PATTERN_LEN; k++) begin
      window[k] = hist[k-1];
    end
  end

  mpm_matcher u_matcher (
    .window      (window),
    .patterns    (patterns_r),
    .lengths     (lengths_r),
    .match_count (count)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_count_nxt = out_count_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = s1_byte_r;
      out_count_nxt = count;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patterns_r  <= '0;
      lengths_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      patterns_r  <= patterns_nxt;
      lengths_r   <= lengths_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r   <= s1_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_match_count = out_count_r;

endmodule

### src/mpm_checker.sv
// Port-level checks for the multi-pattern match marker, bound to the top.
// Depends on mpm_pkg and on multi_pattern_match_marker_unit.
`timescale 1ns / 1ps

module mpm_checker
  import mpm_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [7:0]         in_byte,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         out_byte,
  input logic [COUNT_W-1:0] out_match_count
);

  // A request held back by the block stays put on the input side.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_byte))
    else $error("request changed while stalled");

  // A result held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_match_count))
    else $error("result changed while stalled");

  // Break characters never show up as results.
  a_no_break: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte != BREAK_NL) && (out_byte != BREAK_NUL))
    else $error("break character delivered as a result");

  // At most one hit per pattern.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_match_count <= COUNT_W'(NUM_PATTERNS))
    else $error("match count above the number of patterns");

  // No result is offered in the cycle after reset.
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered right after reset");

endmodule

bind multi_pattern_match_marker_unit mpm_checker u_mpm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_byte         (in_byte),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_match_count (out_match_count)
);
